>>> rtl/core/bqf_pkg.sv
// ----------------------------------------------------------------------------
// Biquad filter package
// Shared widths, defaults, register indexes and the coefficient set type.
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int COEF_W         = 32;
  localparam int CHAN_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CHANNELS_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_FRAC_DEF  = 28;

  // Width used to compare a channel number against any legal channel count.
  localparam int CHAN_CMP_W     = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

endpackage

>>> rtl/core/bqf_hist.sv
// ----------------------------------------------------------------------------
// Biquad channel history
// Keeps the two previous inputs and outputs of every channel in flip-flops.
// ----------------------------------------------------------------------------
module bqf_hist #(
  parameter int CHANNELS    = bqf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic                          wr_en_i,
  input  logic signed [SAMPLE_BITS-1:0] x0_i,
  input  logic signed [SAMPLE_BITS-1:0] y0_i,
  output logic signed [SAMPLE_BITS-1:0] x1_o,
  output logic signed [SAMPLE_BITS-1:0] x2_o,
  output logic signed [SAMPLE_BITS-1:0] y1_o,
  output logic signed [SAMPLE_BITS-1:0] y2_o
);
  import bqf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x1_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2_q [CHANNELS];

  assign x1_o = x1_q[idx_i];
  assign x2_o = x2_q[idx_i];
  assign y1_o = y1_q[idx_i];
  assign y2_o = y2_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      x2_q[idx_i] <= x1_q[idx_i];
      x1_q[idx_i] <= x0_i;
      y2_q[idx_i] <= y1_q[idx_i];
      y1_q[idx_i] <= y0_i;
    end
  end

endmodule

>>> rtl/core/bqf_datapath.sv
// ----------------------------------------------------------------------------
// Biquad arithmetic
// Five products, exact sum, rounding and saturation to the sample width.
// ----------------------------------------------------------------------------
module bqf_datapath #(
  parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_DEF
) (
  input  bqf_pkg::coef_t                coef_i,
  input  logic signed [SAMPLE_BITS-1:0] x0_i,
  input  logic signed [SAMPLE_BITS-1:0] x1_i,
  input  logic signed [SAMPLE_BITS-1:0] x2_i,
  input  logic signed [SAMPLE_BITS-1:0] y1_i,
  input  logic signed [SAMPLE_BITS-1:0] y2_i,
  output logic signed [SAMPLE_BITS-1:0] y_o,
  output logic                          clip_o
);
  import bqf_pkg::*;

  localparam int ProdW = COEF_W + SAMPLE_BITS;
  localparam int AccW  = ProdW + 3;
  localparam int TopLo = COEF_FRAC_BITS + SAMPLE_BITS - 1;
  localparam logic signed [AccW-1:0] RoundK =
    {{(AccW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] MaxV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MinV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [ProdW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [AccW-1:0]  acc;
  logic [AccW-1-TopLo:0]   acc_top;
  logic                    fits;

  assign p_b0 = coef_i.b0 * x0_i;
  assign p_b1 = coef_i.b1 * x1_i;
  assign p_b2 = coef_i.b2 * x2_i;
  assign p_a1 = coef_i.a1 * y1_i;
  assign p_a2 = coef_i.a2 * y2_i;

  assign acc = AccW'(p_b0) + AccW'(p_b1) + AccW'(p_b2)
             - AccW'(p_a1) - AccW'(p_a2) + RoundK;

  // The rounded result fits when everything above its sign bit matches it.
  assign acc_top = acc[AccW-1:TopLo];
  assign fits    = (&acc_top) | ~(|acc_top);

  always_comb begin
    if (fits) begin
      y_o    = acc[TopLo:COEF_FRAC_BITS];
      clip_o = 1'b0;
    end else begin
      y_o    = acc[AccW-1] ? MinV : MaxV;
      clip_o = 1'b1;
    end
  end

endmodule

>>> rtl/core/multichannel_biquad_filter.sv
// ----------------------------------------------------------------------------
// Multichannel biquad filter
// Direct form I biquad shared by all channels, one coefficient set.
//
//   Channel  Signals                                   Direction
//   in       in_valid_i/in_ready_o, channel_i,         input
//            sample_in_i, end_of_block_i
//   out      out_valid_o/out_ready_i, channel_out_o,   output
//            filtered_sample_o, clipped_o, end_of_block_out_o
//   cfg      cfg_valid_i/cfg_ready_o, cfg_index_i,     input
//            cfg_data_i
//
// One beat per cycle sustained unless the output stalls. The result is
// computed in one pass from the input register, through the history read and
// five parallel multipliers, into the output register, and the history is
// updated at the same edge. The output register stalls the input register
// only when both are full. Reset clears the history and loads the
// coefficients with a unity pass-through.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter #(
  parameter int CHANNELS       = bqf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bqf_pkg::CHAN_W-1:0]       channel_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in_i,
  input  logic                             end_of_block_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bqf_pkg::CHAN_W-1:0]       channel_out_o,
  output logic signed [SAMPLE_BITS-1:0]    filtered_sample_o,
  output logic                             clipped_o,
  output logic                             end_of_block_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bqf_pkg::COEF_W-1:0]       cfg_data_i
);
  import bqf_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  coef_t coef_q;

  logic                          s1_valid_q;
  logic [CHAN_W-1:0]             s1_chan_q;
  logic signed [SAMPLE_BITS-1:0] s1_x_q;
  logic                          s1_eob_q;
  logic                          s1_adv;

  logic                          out_valid_q;
  logic [CHAN_W-1:0]             out_chan_q;
  logic signed [SAMPLE_BITS-1:0] out_y_q;
  logic                          out_clip_q;
  logic                          out_eob_q;

  logic [CHAN_CMP_W-1:0]         ch_wide;
  logic                          in_range;
  logic [IdxW-1:0]               hist_idx;
  logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2, y_calc;
  logic                          clip_calc;
  logic signed [SAMPLE_BITS-1:0] y_d;
  logic                          clip_d;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_B0:  coef_q.b0 <= cfg_data_i;
        CFG_B1:  coef_q.b1 <= cfg_data_i;
        CFG_B2:  coef_q.b2 <= cfg_data_i;
        CFG_A1:  coef_q.a1 <= cfg_data_i;
        CFG_A2:  coef_q.a2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_chan_q <= channel_i;
      s1_x_q    <= sample_in_i;
      s1_eob_q  <= end_of_block_i;
    end
  end

  // Channel selection; channels at or beyond the count leave history alone.
  assign ch_wide  = CHAN_CMP_W'(s1_chan_q);
  assign in_range = ch_wide < CHAN_CMP_W'(CHANNELS);
  assign hist_idx = ch_wide[IdxW-1:0];

  bqf_hist #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IdxW)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (hist_idx),
    .wr_en_i (s1_adv && in_range),
    .x0_i    (s1_x_q),
    .y0_i    (y_calc),
    .x1_o    (x1),
    .x2_o    (x2),
    .y1_o    (y1),
    .y2_o    (y2)
  );

  bqf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .coef_i (coef_q),
    .x0_i   (s1_x_q),
    .x1_i   (x1),
    .x2_i   (x2),
    .y1_i   (y1),
    .y2_i   (y2),
    .y_o    (y_calc),
    .clip_o (clip_calc)
  );

  assign y_d    = in_range ? y_calc : '0;
  assign clip_d = in_range && clip_calc;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_chan_q <= s1_chan_q;
      out_y_q    <= y_d;
      out_clip_q <= clip_d;
      out_eob_q  <= s1_eob_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign channel_out_o      = out_chan_q;
  assign filtered_sample_o  = out_y_q;
  assign clipped_o          = out_clip_q;
  assign end_of_block_out_o = out_eob_q;

endmodule

>>> tb/sv/multichannel_biquad_filter_test.sv
// ----------------------------------------------------------------------------
// Multichannel biquad filter testbench
// Drives samples on random channels through the shared direct form I biquad
// under several coefficient sets. Unity, ignored-index, rounding and saturation
// cases come first, then random phases. A local filter predicts every output
// beat and a checker compares each beat with the oldest prediction.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter_test;
  import bqf_pkg::*;

  localparam int NCH   = CHANNELS_DEF;
  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int CFRAC = COEF_FRAC_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 9;
  localparam int PHASE_SAMPLES = 200;

  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam longint SAT_MAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << CFRAC;
  localparam logic signed [COEF_W-1:0] COEF_HALF = COEF_W'(1) << (CFRAC - 1);

  typedef struct {
    logic [CHAN_W-1:0]        ch;
    logic signed [SB-1:0]     y;
    logic                     clip;
    logic                     eob;
  } filt_result_t;

  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_mode_e;
  typedef enum {STYLE_TAME, STYLE_WILD, STYLE_EXTREME} coef_style_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready_o;
  logic [CHAN_W-1:0]    channel;
  logic signed [SB-1:0] sample_in;
  logic                 end_of_block;
  logic                 out_valid_o;
  logic                 out_ready;
  logic [CHAN_W-1:0]    channel_out_o;
  logic signed [SB-1:0] filtered_sample_o;
  logic                 clipped_o;
  logic                 end_of_block_out_o;
  logic                 cfg_valid;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  // Predictor state: coefficient set and per-channel history.
  coef_t                coefs;
  logic signed [SB-1:0] x_prev  [NCH];
  logic signed [SB-1:0] x_older [NCH];
  logic signed [SB-1:0] y_prev  [NCH];
  logic signed [SB-1:0] y_older [NCH];

  filt_result_t pending_outputs[$];
  filt_result_t expected_result;
  int           errors = 0;
  int           burst_left = 0;
  int           cycle_count = 0;

  multichannel_biquad_filter u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .channel_i          (channel),
    .sample_in_i        (sample_in),
    .end_of_block_i     (end_of_block),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .channel_out_o      (channel_out_o),
    .filtered_sample_o  (filtered_sample_o),
    .clipped_o          (clipped_o),
    .end_of_block_out_o (end_of_block_out_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d outputs outstanding", $time, pending_outputs.size());
      $display("multichannel_biquad_filter_test NOT OK");
      $finish;
    end
  end

  // Computes one filtered sample exactly and shifts the channel history.
  function automatic filt_result_t compute_filtered(input logic [CHAN_W-1:0] ch,
                                                    input logic signed [SB-1:0] x,
                                                    input logic eob);
    filt_result_t r;
    longint       acc;
    longint       rounded;
    r.ch   = ch;
    r.eob  = eob;
    r.y    = '0;
    r.clip = 1'b0;
    if (int'(ch) < NCH) begin
      acc = longint'($signed(coefs.b0)) * longint'(x)
          + longint'($signed(coefs.b1)) * longint'(x_prev[ch])
          + longint'($signed(coefs.b2)) * longint'(x_older[ch])
          - longint'($signed(coefs.a1)) * longint'(y_prev[ch])
          - longint'($signed(coefs.a2)) * longint'(y_older[ch])
          + (longint'(1) <<< (CFRAC - 1));
      rounded = acc >>> CFRAC;
      if (rounded > SAT_MAX) begin
        r.y    = SAMPLE_MAX;
        r.clip = 1'b1;
      end else if (rounded < SAT_MIN) begin
        r.y    = SAMPLE_MIN;
        r.clip = 1'b1;
      end else begin
        r.y = rounded[SB-1:0];
      end
      y_older[ch] = y_prev[ch];
      y_prev[ch]  = r.y;
      x_older[ch] = x_prev[ch];
      x_prev[ch]  = x;
    end
    return r;
  endfunction

  function automatic logic signed [SB-1:0] random_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3: begin
        v = int'($urandom_range(0, 512)) - 256;
        return v[SB-1:0];
      end
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef(input coef_style_e style);
    int r;
    r = int'($urandom);
    case (style)
      STYLE_TAME: return r >>> $urandom_range(3, 10);
      STYLE_WILD: return r;
      default: begin
        case ($urandom_range(0, 3))
          0: return COEF_MIN;
          1: return COEF_MAX;
          2: return '0;
          default: return COEF_ONE;
        endcase
      end
    endcase
  endfunction

  // Sends one sample beat; the sender works in bursts with random gaps between.
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [SB-1:0] x,
                             input logic eob);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid     <= 1'b1;
    channel      <= ch;
    sample_in    <= x;
    end_of_block <= eob;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_outputs.push_back(compute_filtered(ch, x, eob));
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register; cfg_valid stays high unless this is the last beat.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_B0:  coefs.b0 = data;
      CFG_B1:  coefs.b1 = data;
      CFG_B2:  coefs.b2 = data;
      CFG_A1:  coefs.a1 = data;
      CFG_A2:  coefs.a2 = data;
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic load_coefs(input coef_t c);
    wait_idle();
    cfg_write(CFG_B0, c.b0, 1'b0);
    cfg_write(CFG_B1, c.b1, 1'b0);
    cfg_write(CFG_B2, c.b2, 1'b0);
    cfg_write(CFG_A1, c.a1, 1'b0);
    cfg_write(CFG_A2, c.a2, 1'b1);
  endtask

  // Reset coefficients pass every sample through unchanged.
  task automatic test_unity_passthrough();
    logic signed [SB-1:0] vals [NCH];
    vals = '{SAMPLE_MIN, SAMPLE_MAX, 24'sd0, -24'sd1, 24'sd1,
             24'h555555, 24'haaaaaa, 24'h0f0f0f};
    for (int ch = 0; ch < NCH; ch++) send_sample(CHAN_W'(ch), vals[ch], ch[0]);
  endtask

  // Writes beyond the last register must leave the coefficients alone.
  task automatic test_ignored_index();
    wait_idle();
    for (int idx = int'(CFG_A2) + 1; idx < 2 ** CFG_IDX_W; idx++)
      cfg_write(CFG_IDX_W'(idx), $urandom, idx == 2 ** CFG_IDX_W - 1);
    send_sample(CHAN_W'(0), random_sample(), 1'b0);
    send_sample(CHAN_W'(1), random_sample(), 1'b1);
  endtask

  // A gain of one half puts odd samples exactly on the rounding midpoint.
  task automatic test_rounding_midpoint();
    coef_t c;
    c = '0;
    c.b0 = COEF_HALF;
    load_coefs(c);
    send_sample(CHAN_W'(2), 24'sd1, 1'b0);
    send_sample(CHAN_W'(2), -24'sd1, 1'b0);
    send_sample(CHAN_W'(2), 24'sd3, 1'b0);
    send_sample(CHAN_W'(2), -24'sd3, 1'b1);
  endtask

  // Extreme coefficients drive the accumulator far past both sample limits.
  task automatic test_saturation();
    coef_t c;
    c.b0 = COEF_MAX;
    c.b1 = COEF_MAX;
    c.b2 = COEF_MAX;
    c.a1 = COEF_MIN;
    c.a2 = COEF_MIN;
    load_coefs(c);
    send_sample(CHAN_W'(3), SAMPLE_MAX, 1'b0);
    send_sample(CHAN_W'(3), SAMPLE_MIN, 1'b0);
    send_sample(CHAN_W'(3), SAMPLE_MAX, 1'b1);
    c = {5{COEF_MIN}};
    load_coefs(c);
    send_sample(CHAN_W'(4), SAMPLE_MIN, 1'b0);
    send_sample(CHAN_W'(4), SAMPLE_MAX, 1'b0);
    send_sample(CHAN_W'(4), 24'sd0, 1'b1);
  endtask

  task automatic test_random_phases();
    coef_t       c;
    coef_style_e style;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        1: style = STYLE_WILD;
        3: style = STYLE_EXTREME;
        default: style = STYLE_TAME;
      endcase
      c.b0 = random_coef(style);
      c.b1 = random_coef(style);
      c.b2 = random_coef(style);
      c.a1 = random_coef(style);
      c.a2 = random_coef(style);
      load_coefs(c);
      for (int i = 0; i < PHASE_SAMPLES; i++)
        send_sample(CHAN_W'($urandom_range(0, NCH - 1)), random_sample(),
                    $urandom_range(0, 7) == 0);
    end
  endtask

  // The receiver switches between stall patterns over stretches of random length.
  initial begin
    ready_mode_e mode;
    int          stretch;
    mode    = READY_ALWAYS;
    stretch = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stretch == 0) begin
        mode    = ready_mode_e'($urandom_range(0, 2));
        stretch = $urandom_range(16, 160);
      end
      stretch--;
      case (mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
        default:      out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat, channel %0d sample %0d",
                 $time, channel_out_o, filtered_sample_o);
      end else begin
        expected_result = pending_outputs.pop_front();
        if (channel_out_o !== expected_result.ch)
          report_mismatch("channel_out", expected_result.ch, channel_out_o);
        if (filtered_sample_o !== expected_result.y)
          report_mismatch("filtered_sample", expected_result.y, filtered_sample_o);
        if (clipped_o !== expected_result.clip)
          report_mismatch("clipped", expected_result.clip, clipped_o);
        if (end_of_block_out_o !== expected_result.eob)
          report_mismatch("end_of_block_out", expected_result.eob, end_of_block_out_o);
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    channel      <= '0;
    sample_in    <= '0;
    end_of_block <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    coefs    = '0;
    coefs.b0 = COEF_ONE;
    for (int ch = 0; ch < NCH; ch++) begin
      x_prev[ch]  = '0;
      x_older[ch] = '0;
      y_prev[ch]  = '0;
      y_older[ch] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unity_passthrough();
    test_ignored_index();
    test_rounding_midpoint();
    test_saturation();
    test_random_phases();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("multichannel_biquad_filter_test OK");
    end else begin
      $display("multichannel_biquad_filter_test NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/bqf_pkg.sv
rtl/core/bqf_hist.sv
rtl/core/bqf_datapath.sv
rtl/core/multichannel_biquad_filter.sv
tb/sv/multichannel_biquad_filter_test.sv
